### src/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg: serial LED command parser package
// Command text, status codes and register indexes shared by the parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

  localparam int unsigned NumCmds   = 4;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CmdPosW   = 3;

  localparam logic [7:0]        LineFeed      = 8'h0A;
  localparam logic [LevelW-1:0] StepSizeReset = 7'd25;
  localparam logic [LevelW-1:0] FullLvlReset  = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSize  = 2'd0,
    CfgFullLevel = 2'd1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StLevelSet = 2'd0,
    StUnknown  = 2'd1,
    StTooLong  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CmdOn  = 2'd0,
    CmdOff = 2'd1,
    CmdBri = 2'd2,
    CmdDim = 2'd3
  } cmd_e;

  // command text, first character in the low byte, zero terminated
  function automatic logic [7:0] cmd_char(input cmd_e cmd, input logic [CmdPosW-1:0] pos);
    logic [63:0] text;
    case (cmd)
      CmdOn:   text = {8'h00, 8'h00, 8'h00, 8'h00, 8'h4E, 8'h4F, 8'h52, 8'h4C};
      CmdOff:  text = {8'h00, 8'h00, 8'h00, 8'h46, 8'h46, 8'h4F, 8'h52, 8'h4C};
      CmdBri:  text = {8'h00, 8'h00, 8'h00, 8'h49, 8'h52, 8'h42, 8'h52, 8'h4C};
      CmdDim:  text = {8'h00, 8'h00, 8'h00, 8'h4D, 8'h49, 8'h44, 8'h52, 8'h4C};
      default: text = '0;
    endcase
    return text[8*pos +: 8];
  endfunction

  function automatic logic [CmdPosW-1:0] cmd_len(input cmd_e cmd);
    logic [CmdPosW-1:0] len;
    case (cmd)
      CmdOn:   len = 3'd4;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

### src/serial_led_command_parser.sv
// ----------------------------------------------------------------------------
// serial_led_command_parser
// Collects serial bytes into a line and turns LRON/LROFF/LRBRI/LRDIM lines
// into a PWM level and a status code.
// ----------------------------------------------------------------------------
//  channel   dir  word                                    handshake
//  s_axis    in   tdata[7:0] rx_byte                      tvalid/tready
//  m_axis    out  tdata[6:0] pwm_level, tuser status      tvalid/tready
//  cfg       in   cfg_index_i register, cfg_data_i value  cfg_valid_i/cfg_ready_o
//
//  one byte is taken every cycle while the skid stage is empty; the command
//  match is tracked per byte, so the line itself is never stored
//  a line feed's result is registered for m_axis, or held in the skid stage
//  a one-word skid stage behind the result register keeps s_axis open while
//  a result waits; s_axis stalls only when both are full
//  reset: level 0, step 25, full level 100, empty line
// ----------------------------------------------------------------------------
module serial_led_command_parser #(
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [6:0] pwm_level, [7] zero
  output logic [1:0]                  m_axis_tuser,   // [1:0] status
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [slcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slcp_pkg::LevelW-1:0]  cfg_data_i
);
  import slcp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_BYTES + 1);
  localparam logic [LenW-1:0] LenFull = LenW'(LINE_BYTES);

  typedef struct packed {
    logic [LevelW-1:0] level;
    status_e           status;
  } result_t;

  logic [LevelW-1:0] step_q, full_q, level_q, level_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [NumCmds-1:0] alive_q, alive_d, done_q, done_d, match;
  logic              acc, is_lf, overflow, store;
  result_t           res, out_q, skid_q;
  logic              out_valid_q, skid_valid_q, res_valid;
  logic [LevelW:0]   bri_sum;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_lf         = (s_axis_tdata == LineFeed);
  assign overflow      = (len_q == LenFull);
  assign store         = acc && !is_lf && !overflow;
  assign res_valid     = acc && is_lf;

  // per command: prefix still matching, or terminated by a zero byte
  always_comb begin
    alive_d = alive_q;
    done_d  = done_q;
    match   = '0;
    for (int c = 0; c < NumCmds; c++) begin
      logic [CmdPosW-1:0] clen;
      logic               hit;
      clen     = cmd_len(cmd_e'(c));
      hit      = alive_q[c] && (len_q <= LenW'(clen))
                 && (s_axis_tdata == cmd_char(cmd_e'(c), len_q[CmdPosW-1:0]));
      match[c] = done_q[c] || (alive_q[c] && (len_q == LenW'(clen)));
      if (res_valid) begin
        alive_d[c] = 1'b1;
        done_d[c]  = 1'b0;
      end else if (store) begin
        alive_d[c] = hit && (s_axis_tdata != 8'h00);
        done_d[c]  = done_q[c] || (hit && (s_axis_tdata == 8'h00));
      end
    end
  end

  always_comb begin
    len_d = len_q;
    if (res_valid) begin
      len_d = '0;
    end else if (store) begin
      len_d = len_q + LenW'(1);
    end
  end

  assign bri_sum = {1'b0, level_q} + {1'b0, step_q};

  always_comb begin
    level_d    = level_q;
    res.status = StLevelSet;
    if (overflow) begin
      res.status = StTooLong;
    end else if (match[CmdOn]) begin
      level_d = full_q;
    end else if (match[CmdOff]) begin
      level_d = '0;
    end else if (match[CmdBri]) begin
      level_d = (bri_sum >= {1'b0, full_q}) ? full_q : bri_sum[LevelW-1:0];
    end else if (match[CmdDim]) begin
      level_d = (level_q <= step_q) ? '0 : level_q - step_q;
    end else begin
      res.status = StUnknown;
    end
    res.level = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepSizeReset;
      full_q  <= FullLvlReset;
      level_q <= '0;
      len_q   <= '0;
      alive_q <= '1;
      done_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgStepSize:  step_q <= cfg_data_i;
          CfgFullLevel: full_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (res_valid) begin
        level_q <= level_d;
      end
      len_q   <= len_d;
      alive_q <= alive_d;
      done_q  <= done_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.level};
  assign m_axis_tuser  = out_q.status;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid word without result word");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenFull) else $error("line length beyond line size");

  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (len_q == '0)) else $error("line feed did not clear the line");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("more than one command matches");

endmodule
